### hw/rtl/sfr_pkg.sv
// Shared types, sizes and helpers for the stream find/replace/truncate block.
// No dependencies; every other file in hw/rtl imports this package.
package sfr_pkg;

  localparam int PATTERN_MAX     = 8;
  localparam int REPLACEMENT_MAX = 8;
  localparam int LIMIT_BITS      = 12;

  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int RIDX_W = (REPLACEMENT_MAX > 1) ? $clog2(REPLACEMENT_MAX) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES     = 3'd0,
    REG_PATTERN_LENGTH    = 3'd1,
    REG_REPLACEMENT_BYTES = 3'd2,
    REG_REPLACEMENT_LEN   = 3'd3,
    REG_OUTPUT_LIMIT      = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIRECT,
    S_CHECK,
    S_REPL,
    S_FLUSH,
    S_END
  } state_t;

  // Per-cell control: load a new character or take the neighbor's.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // Window control from the sequencer.
  typedef struct packed {
    logic              append;
    logic              shift;
    logic [PIDX_W-1:0] slot;
  } win_ctl_t;

  // Clamp a configured length to its maximum.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n,
                                                 input logic [LEN_W-1:0] m);
    return (n > m) ? m : n;
  endfunction

endpackage

### hw/rtl/sfr_text_if.sv
// Input character channel: valid/ready handshake with one source character.
// Depends on sfr_pkg for widths.
interface sfr_text_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              char_valid;
  logic              last_in;

  modport source (output valid, char_in, char_valid, last_in, input ready);
  modport sink   (input valid, char_in, char_valid, last_in, output ready);
endinterface

### hw/rtl/sfr_result_if.sv
// Output channel: valid/ready handshake with one output character or end beat.
// Depends on sfr_pkg for widths.
interface sfr_result_if;
  import sfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CHAR_W-1:0]     char_out;
  logic                  char_present;
  logic                  end_of_string;
  logic [LIMIT_BITS-1:0] written_length;

  modport source (output valid, char_out, char_present, end_of_string, written_length,
                  input ready);
  modport sink   (input valid, char_out, char_present, end_of_string, written_length,
                  output ready);
endinterface

### hw/rtl/sfr_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on sfr_pkg for widths.
interface sfr_cfg_if;
  import sfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/stream_find_replace_truncate_top.sv
// Stream find/replace with output truncation; top level with sequencer and config.
// Depends on sfr_pkg, sfr_text_if, sfr_result_if, sfr_cfg_if and sfr_window.
//
// Characters enter one beat at a time on the text channel. Each leftmost,
// non-overlapping occurrence of the configured pattern (up to 8 bytes) is
// replaced by the configured replacement (up to 8 bytes); other characters
// pass through. Output stops once output_limit characters have been written in
// the current string; later characters are dropped silently. A beat with
// last_in set flushes the pending window as literal text and is followed by an
// end beat (char_present 0, end_of_string 1) carrying the final length, after
// which the counters restart for the next string. A pattern length of zero
// copies input unchanged. The block works on one input beat at a time: a
// character in copy-through mode is accepted and then emitted, a character
// that brings the window to the pattern length is accepted and then compared
// against the window, and a character that only extends a partial window is
// just accepted. A match then emits the replacement characters one at a time,
// and the end of a string releases the pending window bytes one at a time and
// then sends the end beat. Output beats stall the sequencer only while the
// result register is full and not being taken. Writing the pattern bytes or
// pattern length discards the pending window. Configuration is always ready;
// write it while no string is in flight.
module stream_find_replace_truncate_top
  import sfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  sfr_text_if.sink     text,
  sfr_result_if.source result,
  sfr_cfg_if.sink      cfg
);

  // Configuration registers
  logic [CFG_DATA_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]      pattern_length;
  logic [CFG_DATA_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]      replacement_length;
  logic [LIMIT_BITS-1:0] output_limit;

  // Sequencer state
  state_t                state, state_next;
  logic [LEN_W-1:0]      fill, fill_next;
  logic [LIMIT_BITS-1:0] written, written_next;
  logic [RIDX_W-1:0]     rep_idx, rep_idx_next;
  logic [CHAR_W-1:0]     held_char;
  logic                  held_last;

  // Result register
  logic                  out_valid;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_present;
  logic                  out_end;
  logic [LIMIT_BITS-1:0] out_len;

  logic [LEN_W-1:0]  plen, rlen;
  logic              text_accept, cfg_accept, pat_write;
  logic              out_free, room, step_ok;
  logic              char_emit, ld_char, ld_end;
  logic [CHAR_W-1:0] emit_c;
  state_t            after_st;
  win_ctl_t          wctl;
  logic [CHAR_W-1:0] front_char;
  logic              hit;

  assign plen = clamp_len(pattern_length, LEN_W'(PATTERN_MAX));
  assign rlen = clamp_len(replacement_length, LEN_W'(REPLACEMENT_MAX));

  assign text.ready  = (state == S_IDLE);
  assign text_accept = text.valid && text.ready;
  assign cfg.ready   = 1'b1;
  assign cfg_accept  = cfg.valid && cfg.ready;
  assign pat_write   = cfg_accept && ((cfg.index == REG_PATTERN_BYTES) ||
                                      (cfg.index == REG_PATTERN_LENGTH));

  // The result register can take a beat when empty or being drained.
  assign out_free = !out_valid || result.ready;
  // Characters past the limit are dropped, so those steps never wait.
  assign room     = (written < output_limit);
  assign step_ok  = out_free || !room;
  assign after_st = held_last ? S_FLUSH : S_IDLE;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
      output_limit       <= '0;
    end else if (cfg_accept) begin
      case (cfg_reg_t'(cfg.index))
        REG_PATTERN_BYTES:     pattern_bytes      <= cfg.data;
        REG_PATTERN_LENGTH:    pattern_length     <= cfg.data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES: replacement_bytes  <= cfg.data;
        REG_REPLACEMENT_LEN:   replacement_length <= cfg.data[LEN_W-1:0];
        REG_OUTPUT_LIMIT:      output_limit       <= cfg.data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  sfr_window u_window (
    .clk          (clk),
    .ctl          (wctl),
    .char_in      (text.char_in),
    .pattern_bytes(pattern_bytes),
    .plen         (plen),
    .front_char   (front_char),
    .hit          (hit)
  );

  // Next state and outputs of the sequencer
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    written_next = written;
    rep_idx_next = rep_idx;
    char_emit    = 1'b0;
    emit_c       = front_char;
    ld_end       = 1'b0;
    wctl         = '0;
    wctl.slot    = fill[PIDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (text_accept) begin
          if (text.char_valid) begin
            if (plen == '0) begin
              state_next = S_DIRECT;
            end else begin
              // Append the character behind the pending bytes.
              wctl.append = 1'b1;
              fill_next   = fill + 1'b1;
              if (fill + 1'b1 == plen) begin
                state_next = S_CHECK;
              end else begin
                state_next = text.last_in ? S_FLUSH : S_IDLE;
              end
            end
          end else begin
            state_next = text.last_in ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_DIRECT: begin
        char_emit = 1'b1;
        emit_c    = held_char;
        if (step_ok) begin
          state_next = after_st;
        end
      end
      S_CHECK: begin
        if (hit) begin
          if (rlen == '0) begin
            fill_next  = '0;
            state_next = after_st;
          end else begin
            rep_idx_next = '0;
            state_next   = S_REPL;
          end
        end else begin
          // Release the front byte as literal text and slide by one.
          char_emit = 1'b1;
          if (step_ok) begin
            wctl.shift = 1'b1;
            fill_next  = fill - 1'b1;
            state_next = after_st;
          end
        end
      end
      S_REPL: begin
        char_emit = 1'b1;
        emit_c    = replacement_bytes[CHAR_W*rep_idx +: CHAR_W];
        if (step_ok) begin
          rep_idx_next = rep_idx + 1'b1;
          if (LEN_W'(rep_idx) + 1'b1 == rlen) begin
            fill_next  = '0;
            state_next = after_st;
          end
        end
      end
      S_FLUSH: begin
        if (fill == '0) begin
          state_next = S_END;
        end else begin
          char_emit = 1'b1;
          if (step_ok) begin
            wctl.shift = 1'b1;
            fill_next  = fill - 1'b1;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          ld_end       = 1'b1;
          written_next = '0;
          fill_next    = '0;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    ld_char = char_emit && room && out_free;
    if (ld_char) begin
      written_next = written + 1'b1;
    end

    // A pattern change restarts the matcher.
    if (pat_write) begin
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      written <= '0;
      rep_idx <= '0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      written <= written_next;
      rep_idx <= rep_idx_next;
    end
  end

  // Hold the accepted beat for later steps.
  always_ff @(posedge clk) begin
    if (text_accept) begin
      held_char <= text.char_in;
      held_last <= text.last_in;
    end
  end

  // Result register: load a beat, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_char || ld_end) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_char) begin
      out_char    <= emit_c;
      out_present <= 1'b1;
      out_end     <= 1'b0;
      out_len     <= written + 1'b1;
    end else if (ld_end) begin
      out_char    <= '0;
      out_present <= 1'b0;
      out_end     <= 1'b1;
      out_len     <= written;
    end
  end

  assign result.valid          = out_valid;
  assign result.char_out       = out_char;
  assign result.char_present   = out_present;
  assign result.end_of_string  = out_end;
  assign result.written_length = out_len;

  // The window never holds more than a full pattern.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LEN_W'(PATTERN_MAX))
    else $error("window fill beyond pattern maximum");

  // A waiting end beat means the length counter has already restarted.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.end_of_string) |-> (written == '0))
    else $error("length counter not cleared behind end beat");

  // A result beat is either a character or the end marker.
  a_beat_kind: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.char_present != result.end_of_string))
    else $error("result beat is neither character nor end");

  // Replacement only runs with a non-empty replacement.
  a_repl_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPL) |-> (rlen != '0))
    else $error("replacement step with empty replacement");

  // A check follows an append that filled the window to pattern length.
  a_check_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (fill == plen))
    else $error("compare started with partial window");

endmodule

### hw/rtl/sfr_cell.sv
// One window cell: holds a character, compares it with its pattern byte.
// Depends on sfr_pkg.
module sfr_cell
  import sfr_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CHAR_W-1:0] load_char,
  input  logic [CHAR_W-1:0] neighbor_char,
  input  logic [CHAR_W-1:0] pat_char,
  output logic [CHAR_W-1:0] char_q,
  output logic              match
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      char_q <= load_char;
    end else if (ctl.shift) begin
      char_q <= neighbor_char;
    end
  end

  assign match = (char_q == pat_char);

endmodule

### hw/rtl/sfr_window.sv
// Sliding window: a row of sfr_cell instances that shift toward the front.
// Depends on sfr_pkg and sfr_cell.
module sfr_window
  import sfr_pkg::*;
(
  input  logic                  clk,
  input  win_ctl_t              ctl,
  input  logic [CHAR_W-1:0]     char_in,
  input  logic [CFG_DATA_W-1:0] pattern_bytes,
  input  logic [LEN_W-1:0]      plen,
  output logic [CHAR_W-1:0]     front_char,
  output logic                  hit
);

  logic [CHAR_W-1:0]      chars [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] match;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    cell_ctl_t         cctl;
    logic [CHAR_W-1:0] neighbor;

    assign cctl.load  = ctl.append && (ctl.slot == PIDX_W'(i));
    assign cctl.shift = ctl.shift;

    if (i == PATTERN_MAX - 1) begin : g_tail
      assign neighbor = chars[i];
    end else begin : g_mid
      assign neighbor = chars[i+1];
    end

    sfr_cell u_cell (
      .clk          (clk),
      .ctl          (cctl),
      .load_char    (char_in),
      .neighbor_char(neighbor),
      .pat_char     (pattern_bytes[CHAR_W*i +: CHAR_W]),
      .char_q       (chars[i]),
      .match        (match[i])
    );
  end

  // Hit when every cell inside the pattern length matches.
  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((LEN_W'(i) < plen) && !match[i]) begin
        hit = 1'b0;
      end
    end
  end

  assign front_char = chars[0];

endmodule

### test/sfr_output_checker.sv
// Scoreboard for stream_find_replace_truncate_top: mirrors the configuration and
// the match window, predicts every output beat and compares it with the result channel.
// Depends on sfr_pkg, sfr_text_if, sfr_result_if and sfr_cfg_if.
module sfr_output_checker
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sfr_text_if         text,
  sfr_result_if       result,
  sfr_cfg_if          cfg,
  output int unsigned owed_count,
  output int unsigned error_count
);

  localparam int REPORT_MAX   = 10;
  localparam int WINDOW_DEPTH = 8;

  typedef struct packed {
    logic [CHAR_W-1:0]     ch;
    logic                  present;
    logic                  eos;
    logic [LIMIT_BITS-1:0] len;
  } out_beat_t;

  logic [CFG_DATA_W-1:0] pat_bytes;
  logic [CFG_DATA_W-1:0] rep_bytes;
  logic [LEN_W-1:0]      pat_len;
  logic [LEN_W-1:0]      rep_len;
  logic [LIMIT_BITS-1:0] char_limit;
  logic [CHAR_W-1:0]     window [WINDOW_DEPTH];
  int unsigned           window_fill;
  logic [LIMIT_BITS-1:0] chars_written;
  out_beat_t             owed_output [$];
  out_beat_t             seen;
  out_beat_t             want;

  // Write one character unless the string already hit its limit.
  function automatic void emit_char(logic [CHAR_W-1:0] c);
    if (chars_written < char_limit) begin
      chars_written = chars_written + 1'b1;
      owed_output.push_back('{c, 1'b1, 1'b0, chars_written});
    end
  endfunction

  function automatic void drop_front(int unsigned n);
    for (int unsigned i = 0; i + n < window_fill && i + n < WINDOW_DEPTH; i++)
      window[i] = window[i + n];
    window_fill = (n >= window_fill) ? 0 : window_fill - n;
  endfunction

  // Advance the matcher by one input beat and queue the output it owes.
  function automatic void rewrite_beat(logic [CHAR_W-1:0] c, logic cv, logic last);
    int unsigned plen;
    int unsigned rlen;
    logic        hit;
    plen = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    rlen = (rep_len > REPLACEMENT_MAX) ? REPLACEMENT_MAX : rep_len;
    if (cv) begin
      if (plen == 0) begin
        emit_char(c);
      end else begin
        if (window_fill < WINDOW_DEPTH) begin
          window[window_fill] = c;
          window_fill++;
        end
        if (window_fill >= plen) begin
          hit = 1'b1;
          for (int unsigned i = 0; i < plen; i++)
            if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
          if (hit) begin
            for (int unsigned i = 0; i < rlen; i++) emit_char(rep_bytes[8*i +: 8]);
            drop_front(plen);
          end else begin
            emit_char(window[0]);
            drop_front(1);
          end
        end
      end
    end
    if (last) begin
      for (int unsigned i = 0; i < window_fill && i < WINDOW_DEPTH; i++) emit_char(window[i]);
      owed_output.push_back('{'0, 1'b0, 1'b1, chars_written});
      window_fill   = 0;
      chars_written = '0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pat_bytes     = '0;
      rep_bytes     = '0;
      pat_len       = '0;
      rep_len       = '0;
      char_limit    = '0;
      window_fill   = 0;
      chars_written = '0;
      foreach (window[i]) window[i] = '0;
      owed_output.delete();
      error_count   = 0;
    end else begin
      if (result.valid && result.ready) begin
        seen = '{result.char_out, result.char_present, result.end_of_string,
                 result.written_length};
        if (owed_output.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("unexpected output beat: char %02h present %0b end %0b length %0d",
                     seen.ch, seen.present, seen.eos, seen.len);
        end else begin
          want = owed_output.pop_front();
          if (seen !== want) begin
            error_count++;
            if (error_count <= REPORT_MAX)
              $display("output beat: expected char %02h present %0b end %0b length %0d, %s",
                       want.ch, want.present, want.eos, want.len,
                       $sformatf("got char %02h present %0b end %0b length %0d",
                                 seen.ch, seen.present, seen.eos, seen.len));
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PATTERN_BYTES: begin
            pat_bytes   = cfg.data;
            window_fill = 0;
          end
          REG_PATTERN_LENGTH: begin
            pat_len     = cfg.data[LEN_W-1:0];
            window_fill = 0;
          end
          REG_REPLACEMENT_BYTES: rep_bytes  = cfg.data;
          REG_REPLACEMENT_LEN:   rep_len    = cfg.data[LEN_W-1:0];
          REG_OUTPUT_LIMIT:      char_limit = cfg.data[LIMIT_BITS-1:0];
          default: ;
        endcase
      end
      if (text.valid && text.ready)
        rewrite_beat(text.char_in, text.char_valid, text.last_in);
    end
    owed_count = owed_output.size();
  end

endmodule

### test/tb_stream_find_replace_truncate_top.sv
// Testbench top for stream_find_replace_truncate_top: drives text and config beats,
// takes results with random back-pressure and reports the scoreboard verdict.
// Depends on sfr_pkg, the channel interfaces, the block and sfr_output_checker.
module tb_stream_find_replace_truncate_top;
  import sfr_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 240;
  localparam int SETTLE_CYCLES = 24;     // flush of a full window plus end beat, with margin
  localparam int DRAIN_CYCLES  = 40;
  localparam int CHOKE_CYCLES  = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LIMIT_TOP     = (1 << LIMIT_BITS) - 1;
  localparam int LEN_TOP       = (1 << LEN_W) - 1;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_INDEX = 3'd7;  // no register behind it

  logic clk = 1'b0;
  logic rst = 1'b1;

  int unsigned owed_count;
  int unsigned error_count;
  int unsigned cycle_count = 0;
  int unsigned random_items = 0;

  // Idle switches, written by the stimulus process only.
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;

  // Long receiver hold-offs: the stimulus asks, the receiver serves.
  int unsigned choke_requests = 0;
  int unsigned choke_served = 0;

  // Pattern in force, used to build strings that actually match.
  logic [CFG_DATA_W-1:0] pattern_now = '0;
  int unsigned           pattern_span = 0;
  logic [CHAR_W-1:0]     alphabet [3];

  sfr_text_if   text_ch ();
  sfr_result_if result_ch ();
  sfr_cfg_if    cfg_ch ();

  stream_find_replace_truncate_top dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  sfr_output_checker rewrite_check (
    .clk         (clk),
    .rst         (rst),
    .text        (text_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .owed_count  (owed_count),
    .error_count (error_count)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog: a hung handshake or a missing beat ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run exceeded %0d cycles with %0d beats still owed", CYCLE_LIMIT, owed_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: insert a random stall before each beat while rx_idle is set, and hold off
  // for a long stretch whenever the stimulus asks, so the block backs up.
  initial begin : result_taker
    int unsigned stall;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (choke_served != choke_requests) begin
        choke_served++;
        result_ch.ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
      end
      stall = rx_idle ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  // Offer one text beat at a falling edge and hold it until accepted.
  // Leaves valid high so a back-to-back beat needs no extra edge.
  task automatic send_beat(logic [CHAR_W-1:0] c, logic cv, logic last);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_ch.valid      <= 1'b1;
    text_ch.char_in    <= c;
    text_ch.char_valid <= cv;
    text_ch.last_in    <= last;
    do @(posedge clk); while (!text_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed beat is out, then let the sequencer
  // finish any beat that owes nothing.
  task automatic settle();
    text_ch.valid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Reprogram all registers with the block idle.
  task automatic configure(logic [CFG_DATA_W-1:0] pat, int unsigned plen,
                           logic [CFG_DATA_W-1:0] rep, int unsigned rlen,
                           int unsigned lim, bit poke_spare = 1'b0);
    settle();
    if (poke_spare) cfg_write(SPARE_REG_INDEX, '1);
    cfg_write(REG_PATTERN_BYTES, pat);
    cfg_write(REG_PATTERN_LENGTH, CFG_DATA_W'(plen));
    cfg_write(REG_REPLACEMENT_BYTES, rep);
    cfg_write(REG_REPLACEMENT_LEN, CFG_DATA_W'(rlen));
    cfg_write(REG_OUTPUT_LIMIT, CFG_DATA_W'(lim));
    cfg_ch.valid <= 1'b0;
    pattern_now  = pat;
    pattern_span = (plen > PATTERN_MAX) ? PATTERN_MAX : plen;
  endtask

  // Pack up to eight characters, first one in the lowest byte.
  function automatic logic [CFG_DATA_W-1:0] pack_chars(string s);
    logic [CFG_DATA_W-1:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  // Send a literal string; end it on its last character or on a bare end beat.
  task automatic send_text(string s, bit end_on_char);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], 1'b1, end_on_char && i == s.len() - 1);
    if (!end_on_char || s.len() == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // Build a string mostly out of whole patterns, pattern prefixes and a small
  // alphabet shared with the pattern, so partial and back-to-back matches are
  // common; sprinkle in arbitrary bytes and ignored empty beats.
  task automatic send_random_string(int unsigned parts);
    logic [CHAR_W-1:0] text_q [$];
    int unsigned       span;
    int unsigned       cut;
    bit                end_on_char;
    span = (pattern_span == 0) ? 1 : pattern_span;
    repeat (parts) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int i = 0; i < span; i++) text_q.push_back(pattern_now[8*i +: 8]);
        end
        4, 5: begin
          cut = $urandom_range(1, span);
          for (int i = 0; i < cut; i++) text_q.push_back(pattern_now[8*i +: 8]);
          text_q.push_back(alphabet[$urandom_range(0, 2)]);
        end
        6, 7, 8: text_q.push_back(alphabet[$urandom_range(0, 2)]);
        default: text_q.push_back(8'($urandom));
      endcase
    end
    end_on_char = ($urandom_range(0, 1) == 1) && (text_q.size() != 0);
    foreach (text_q[i]) begin
      if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(text_q[i], 1'b1, end_on_char && i == text_q.size() - 1);
      random_items++;
    end
    if (!end_on_char) begin
      send_beat(8'($urandom), 1'b0, 1'b1);
      random_items++;
    end
  endtask

  // Draw a fresh setting: short patterns mostly, with the copy-through case,
  // the full-length case and over-length values that clamp.
  task automatic random_configure();
    logic [CFG_DATA_W-1:0] pat;
    int unsigned           plen;
    int unsigned           lim;
    for (int k = 0; k < 3; k++) alphabet[k] = 8'($urandom);
    for (int k = 0; k < 8; k++)
      pat[8*k +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : alphabet[$urandom_range(0, 2)];
    case ($urandom_range(0, 9))
      0:       plen = 0;
      1:       plen = PATTERN_MAX;
      2:       plen = $urandom_range(PATTERN_MAX + 1, LEN_TOP);
      default: plen = $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 7))
      0:       lim = 0;
      1:       lim = LIMIT_TOP;
      2, 3:    lim = $urandom_range(1, 12);
      default: lim = $urandom_range(13, LIMIT_TOP);
    endcase
    configure(pat, plen, {$urandom, $urandom}, $urandom_range(0, LEN_TOP), lim);
  endtask

  initial begin : stimulus
    int unsigned phase;
    text_ch.valid      = 1'b0;
    text_ch.char_in    = '0;
    text_ch.char_valid = 1'b0;
    text_ch.last_in    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // Reset setting: copy-through with a zero limit, so only the end beat shows.
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);

    // Two-byte pattern: overlapping candidate, an ignored empty beat, a match
    // in the middle, a character riding on the end beat, then an empty string.
    configure(pack_chars("ab"), 2, pack_chars("XYZ"), 3, LIMIT_TOP);
    send_beat("a", 1'b1, 1'b0);
    send_beat("a", 1'b1, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b0);
    send_text("bca", 1'b1);
    send_beat(8'hC3, 1'b0, 1'b1);

    // Over-length pattern and replacement clamp to eight; the match completes
    // on the very beat that ends the string.
    configure(pack_chars("ABCDEFGH"), LEN_TOP, pack_chars("01234567"), LEN_TOP, LIMIT_TOP);
    send_text("ABCDEFGH", 1'b1);

    // Copy-through truncated at two characters; also poke an unmapped index.
    configure(pack_chars("ab"), 0, '0, 0, 2, 1'b1);
    send_beat(8'h55, 1'b1, 1'b0);
    send_beat(8'hAA, 1'b1, 1'b0);
    send_beat(8'h0F, 1'b1, 1'b0);
    send_beat(8'hF0, 1'b0, 1'b1);

    // Empty replacement deletes every match.
    configure(pack_chars("a"), 1, '0, 0, LIMIT_TOP);
    send_text("aba", 1'b0);

    // Random phases: new setting, idle mix, a few strings each.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      random_configure();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (phase == 2 || phase == 7) begin
        // Flood the input while the receiver holds off.
        tx_idle = 1'b0;
        choke_requests++;
        send_random_string(24);
      end
      repeat ($urandom_range(2, 4)) send_random_string($urandom_range(0, 8));
      phase++;
    end

    // Drain everything owed, then give stray beats a chance to show.
    text_ch.valid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
